[design/sfcp_pkg.sv]
// ----------------------------------------------------------------------------
// sfcp_pkg
// Shared types, microcode format and CRC helper for the status frame packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfcp_pkg;

  localparam int unsigned PayloadUsed = 13;   // payload bytes held per snapshot
  localparam int unsigned SrcIdxW     = 4;    // index into the payload store
  localparam int unsigned PayCntW     = 3;    // payload bytes within a block
  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [15:0] CrcPoly     = 16'hA001;
  localparam logic [1:0]  LastBlk     = 2'd3;

  typedef logic [7:0]           byte_t;
  typedef logic [1:0]           blk_t;
  typedef logic [SrcIdxW-1:0]   src_idx_t;
  typedef logic [PayCntW-1:0]   pay_cnt_t;
  typedef byte_t [PayloadUsed-1:0] snap_bytes_t;

  // microcode step addresses
  typedef logic [1:0] step_t;
  localparam step_t StepTag   = 2'd0;
  localparam step_t StepPay   = 2'd1;
  localparam step_t StepCrcLo = 2'd2;
  localparam step_t StepCrcHi = 2'd3;

  typedef enum logic [1:0] {
    SRC_TAG,
    SRC_PAY,
    SRC_CRC_LO,
    SRC_CRC_HI
  } src_sel_e;

  typedef enum logic [1:0] {
    COND_NEXT,       // fall through to the next step
    COND_PAY_MORE,   // jump while the block has payload left
    COND_BLK_MORE    // jump while blocks remain, else end of program
  } cond_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  typedef struct packed {
    src_sel_e src;
    logic     crc_init;
    logic     crc_feed;
    logic     blk_end;
    cond_e    cond;
    step_t    target;
  } ucode_t;

  // sequencer -> datapath
  typedef struct packed {
    logic     adv;
    src_sel_e src;
    logic     crc_init;
    logic     crc_feed;
    logic     blk_end;
    logic     last;
    blk_t     blk;
    src_idx_t src_idx;
  } dp_ctrl_t;

  function automatic pay_cnt_t blk_pay_len(blk_t blk);
    pay_cnt_t len;
    unique case (blk)
      2'd0:    len = 3'd5;
      2'd1:    len = 3'd3;
      2'd2:    len = 3'd1;
      default: len = 3'd4;
    endcase
    return len;
  endfunction

  // one byte through the reflected Modbus CRC-16
  function automatic logic [15:0] crc16_feed(logic [15:0] crc, byte_t data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[design/sfcp_if.sv]
// ----------------------------------------------------------------------------
// sfcp_if
// Request channels of the packer: status snapshot in, frame bytes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sfcp_snap_if;
  logic        valid;
  logic        ready;
  logic [7:0]  record_byte_0;
  logic [7:0]  record_byte_1;
  logic [7:0]  record_byte_2;
  logic [7:0]  record_byte_3;
  logic [7:0]  record_byte_4;
  logic [7:0]  serial_byte_0;
  logic [7:0]  serial_byte_1;
  logic [7:0]  serial_byte_2;
  logic [7:0]  charge_level;
  logic [7:0]  health_level;
  logic [15:0] cycle_count;
  logic [7:0]  device_state;

  modport source (
    output valid, record_byte_0, record_byte_1, record_byte_2, record_byte_3,
           record_byte_4, serial_byte_0, serial_byte_1, serial_byte_2,
           charge_level, health_level, cycle_count, device_state,
    input  ready
  );
  modport sink (
    input  valid, record_byte_0, record_byte_1, record_byte_2, record_byte_3,
           record_byte_4, serial_byte_0, serial_byte_1, serial_byte_2,
           charge_level, health_level, cycle_count, device_state,
    output ready
  );
endinterface

interface sfcp_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       block_end;
  logic       frame_last;

  modport source (
    output valid, frame_byte, block_end, frame_last,
    input  ready
  );
  modport sink (
    input  valid, frame_byte, block_end, frame_last,
    output ready
  );
endinterface

[design/sfcp_ucode_rom.sv]
// ----------------------------------------------------------------------------
// sfcp_ucode_rom
// Control store: one control word per sequencer step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcp_ucode_rom (
  input  sfcp_pkg::step_t  step_i,
  output sfcp_pkg::ucode_t word_o
);
  import sfcp_pkg::*;

  // tag: restart CRC and feed tag; pay: loop over block payload;
  // lo/hi: send CRC, hi loops back to tag until the last block
  always_comb begin
    unique case (step_i)
      StepTag:   word_o = '{src: SRC_TAG, crc_init: 1'b1, crc_feed: 1'b1,
                            blk_end: 1'b0, cond: COND_NEXT, target: StepTag};
      StepPay:   word_o = '{src: SRC_PAY, crc_init: 1'b0, crc_feed: 1'b1,
                            blk_end: 1'b0, cond: COND_PAY_MORE, target: StepPay};
      StepCrcLo: word_o = '{src: SRC_CRC_LO, crc_init: 1'b0, crc_feed: 1'b0,
                            blk_end: 1'b0, cond: COND_NEXT, target: StepTag};
      default:   word_o = '{src: SRC_CRC_HI, crc_init: 1'b0, crc_feed: 1'b0,
                            blk_end: 1'b1, cond: COND_BLK_MORE, target: StepTag};
    endcase
  end

endmodule

[design/sfcp_sequencer.sv]
// ----------------------------------------------------------------------------
// sfcp_sequencer
// Step counter, block and payload counters, jump logic over the control store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcp_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               snap_valid_i,
  output logic               snap_ready_o,
  input  logic               slot_free_i,
  output sfcp_pkg::dp_ctrl_t ctrl_o
);
  import sfcp_pkg::*;

  seq_state_e state_q, state_d;
  step_t      step_q, step_d;
  blk_t       blk_q, blk_d;
  pay_cnt_t   cnt_q, cnt_d;
  src_idx_t   src_q, src_d;
  ucode_t     uw;
  logic       accept;
  logic       adv;
  logic       taken;
  logic       prog_end;

  sfcp_ucode_rom u_rom (
    .step_i (step_q),
    .word_o (uw)
  );

  assign accept = snap_valid_i && snap_ready_o;

  always_comb begin
    unique case (uw.cond)
      COND_PAY_MORE: taken = (cnt_q != blk_pay_len(blk_q) - 3'd1);
      COND_BLK_MORE: taken = (blk_q != LastBlk);
      default:       taken = 1'b0;
    endcase
  end

  assign prog_end = (uw.cond == COND_BLK_MORE) && !taken;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: if (accept)          state_d = SEQ_RUN;
      SEQ_RUN:  if (adv && prog_end) state_d = SEQ_IDLE;
      default:  state_d = SEQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    snap_ready_o = (state_q == SEQ_IDLE);
    adv          = (state_q == SEQ_RUN) && slot_free_i;
  end

  always_comb begin
    step_d = step_q;
    blk_d  = blk_q;
    cnt_d  = cnt_q;
    src_d  = src_q;
    if (accept) begin
      step_d = StepTag;
      blk_d  = '0;
      cnt_d  = '0;
      src_d  = '0;
    end else if (adv) begin
      step_d = taken ? uw.target : step_q + 2'd1;
      if (uw.src == SRC_PAY) begin
        src_d = src_q + 4'd1;
        cnt_d = taken ? cnt_q + 3'd1 : '0;
      end
      if (uw.blk_end) begin
        blk_d = blk_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      step_q  <= StepTag;
      blk_q   <= '0;
      cnt_q   <= '0;
      src_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      blk_q   <= blk_d;
      cnt_q   <= cnt_d;
      src_q   <= src_d;
    end
  end

  always_comb begin
    ctrl_o.adv      = adv;
    ctrl_o.src      = uw.src;
    ctrl_o.crc_init = uw.crc_init;
    ctrl_o.crc_feed = uw.crc_feed;
    ctrl_o.blk_end  = uw.blk_end;
    ctrl_o.last     = prog_end;
    ctrl_o.blk      = blk_q;
    ctrl_o.src_idx  = src_q;
  end

endmodule

[design/sfcp_datapath.sv]
// ----------------------------------------------------------------------------
// sfcp_datapath
// Payload store, CRC register, byte select and the output slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcp_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  sfcp_pkg::snap_bytes_t snap_i,
  input  sfcp_pkg::dp_ctrl_t    ctrl_i,
  output logic                  slot_free_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            frame_byte_o,
  output logic                  block_end_o,
  output logic                  frame_last_o
);
  import sfcp_pkg::*;

  snap_bytes_t payload_q;
  logic [15:0] crc_q, crc_d;
  byte_t       sel_byte;
  logic        valid_q, valid_d;
  byte_t       byte_q;
  logic        end_q;
  logic        last_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      payload_q <= snap_i;
    end
  end

  always_comb begin
    unique case (ctrl_i.src)
      SRC_TAG:    sel_byte = {6'b0, ctrl_i.blk};
      SRC_PAY:    sel_byte = payload_q[ctrl_i.src_idx];
      SRC_CRC_LO: sel_byte = crc_q[7:0];
      default:    sel_byte = crc_q[15:8];
    endcase
  end

  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.adv && ctrl_i.crc_feed) begin
      crc_d = crc16_feed(ctrl_i.crc_init ? CrcInit : crc_q, sel_byte);
    end
  end

  assign slot_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.adv) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      crc_q   <= CrcInit;
    end else begin
      valid_q <= valid_d;
      crc_q   <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      byte_q <= sel_byte;
      end_q  <= ctrl_i.blk_end;
      last_q <= ctrl_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign frame_byte_o = byte_q;
  assign block_end_o  = end_q;
  assign frame_last_o = last_q;

endmodule

[design/status_frame_crc_packer.sv]
// ----------------------------------------------------------------------------
// status_frame_crc_packer
// Packs one status snapshot into a 25-byte frame of four tagged sub-blocks,
// each closed by a Modbus CRC-16 (low byte first).
//
//   channel   dir   contents                                   handshake
//   snap_i    in    record, serial, charge, health, cycles,    valid/ready
//                   device state
//   frame_o   out   frame_byte, block_end, frame_last          valid/ready
//
// A snapshot is accepted, then the sequencer runs 25 steps in which it issues
// one frame byte per cycle, unless frame_o stalls, into a single output
// register and feeds each tag and payload byte into the CRC.
// snap_i.ready is high whenever no frame is being generated; the next
// snapshot is taken once the last byte sits in the output register.
// Backpressure on frame_o holds the sequencer in place.
// Reset clears the sequencer, the CRC and the output valid flag; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module status_frame_crc_packer (
  input  logic                clk_i,
  input  logic                rst_ni,
  sfcp_snap_if.sink           snap_i,
  sfcp_frame_if.source        frame_o
);
  import sfcp_pkg::*;

  dp_ctrl_t    ctrl;
  snap_bytes_t snap_bytes;
  logic        slot_free;
  logic        load;

  assign load = snap_i.valid && snap_i.ready;

  assign snap_bytes[0]  = snap_i.record_byte_0;
  assign snap_bytes[1]  = snap_i.record_byte_1;
  assign snap_bytes[2]  = snap_i.record_byte_2;
  assign snap_bytes[3]  = snap_i.record_byte_3;
  assign snap_bytes[4]  = snap_i.record_byte_4;
  assign snap_bytes[5]  = snap_i.serial_byte_0;
  assign snap_bytes[6]  = snap_i.serial_byte_1;
  assign snap_bytes[7]  = snap_i.serial_byte_2;
  assign snap_bytes[8]  = snap_i.charge_level;
  assign snap_bytes[9]  = snap_i.health_level;
  assign snap_bytes[10] = snap_i.cycle_count[7:0];
  assign snap_bytes[11] = snap_i.cycle_count[15:8];
  assign snap_bytes[12] = snap_i.device_state;

  sfcp_sequencer u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_i.valid),
    .snap_ready_o (snap_i.ready),
    .slot_free_i  (slot_free),
    .ctrl_o       (ctrl)
  );

  sfcp_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .snap_i       (snap_bytes),
    .ctrl_i       (ctrl),
    .slot_free_o  (slot_free),
    .out_valid_o  (frame_o.valid),
    .out_ready_i  (frame_o.ready),
    .frame_byte_o (frame_o.frame_byte),
    .block_end_o  (frame_o.block_end),
    .frame_last_o (frame_o.frame_last)
  );

endmodule

[design/sfcp_checker.sv]
// ----------------------------------------------------------------------------
// sfcp_checker
// Port-level checks of the status frame packer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] frame_byte_i,
  input logic       block_end_i,
  input logic       frame_last_i
);

  // a frame is in flight right after a snapshot is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("snapshot ready right after accept");

  // ready only comes back with the closing byte of the frame in the slot
  a_ready_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_i) |-> out_valid_i && frame_last_i)
    else $error("ready returned without final frame byte pending");

  // the final byte also closes block 3
  a_last_ends_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_last_i |-> block_end_i)
    else $error("frame_last without block_end");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(frame_byte_i)
      && $stable(block_end_i) && $stable(frame_last_i))
    else $error("stalled frame byte changed");

endmodule

bind status_frame_crc_packer sfcp_checker u_sfcp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (snap_i.valid),
  .in_ready_i   (snap_i.ready),
  .out_valid_i  (frame_o.valid),
  .out_ready_i  (frame_o.ready),
  .frame_byte_i (frame_o.frame_byte),
  .block_end_i  (frame_o.block_end),
  .frame_last_i (frame_o.frame_last)
);

[sim/status_frame_crc_packer_tb.sv]
// ----------------------------------------------------------------------------
// status_frame_crc_packer_tb
// Self-checking bench for the status frame packer. Snapshots go in on a
// valid/ready channel and each one is predicted as 25 frame bytes: four tagged
// sub-blocks, each closed by a Modbus CRC-16. Every byte that leaves the block
// is checked in order against that prediction. The bench runs corner-value
// requests, a long output stall that backs up the input, and random traffic
// with bursty input and random or patterned output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module status_frame_crc_packer_tb;

  import sfcp_pkg::*;

  localparam int unsigned CycleLimit = 250000;
  localparam int unsigned FrameLen   = 25;
  localparam int unsigned MaxReports = 10;
  localparam logic [15:0] CrcSeed    = 16'hFFFF;
  localparam logic [15:0] CrcPolyRev = 16'hA001;

  typedef struct packed {
    byte_t [4:0] rec;
    byte_t [2:0] ser;
    byte_t       charge;
    byte_t       health;
    logic [15:0] cycles;
    byte_t       state;
  } snap_t;

  typedef struct packed {
    byte_t data;
    logic  blk_end;
    logic  last;
  } frame_beat_t;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_PATTERN,
    RX_MOSTLY
  } rx_mode_e;

  class frame_beat_checker;
    frame_beat_t expected_q[$];
    int unsigned errors;
    int unsigned beats_seen;
    int unsigned frame_pos;

    function new();
      errors     = 0;
      beats_seen = 0;
      frame_pos  = 0;
    endfunction

    // bit-serial form of the reflected CRC, LSB of the data first
    static function logic [15:0] crc_update(logic [15:0] crc, byte_t d);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb  = crc[0] ^ d[i];
        crc = crc >> 1;
        if (fb) begin
          crc = crc ^ CrcPolyRev;
        end
      end
      return crc;
    endfunction

    static function int unsigned payload_len(int unsigned blk);
      case (blk)
        0:       return 5;
        1:       return 3;
        2:       return 1;
        default: return 4;
      endcase
    endfunction

    function void add_beat(byte_t d, logic blk_end);
      frame_beat_t b;
      b.data    = d;
      b.blk_end = blk_end;
      b.last    = (frame_pos == FrameLen - 1);
      expected_q.push_back(b);
      frame_pos = (frame_pos + 1) % FrameLen;
    endfunction

    function void note_snapshot(snap_t s);
      byte_t       pay [13];
      logic [15:0] crc;
      int unsigned src;
      for (int k = 0; k < 5; k++) begin
        pay[k] = s.rec[k];
      end
      for (int k = 0; k < 3; k++) begin
        pay[5 + k] = s.ser[k];
      end
      pay[8]  = s.charge;
      pay[9]  = s.health;
      pay[10] = s.cycles[7:0];
      pay[11] = s.cycles[15:8];
      pay[12] = s.state;
      src       = 0;
      frame_pos = 0;
      for (int unsigned blk = 0; blk < 4; blk++) begin
        crc = crc_update(CrcSeed, byte_t'(blk));
        add_beat(byte_t'(blk), 1'b0);
        for (int unsigned k = 0; k < payload_len(blk); k++) begin
          crc = crc_update(crc, pay[src]);
          add_beat(pay[src], 1'b0);
          src++;
        end
        add_beat(crc[7:0], 1'b0);
        add_beat(crc[15:8], 1'b1);
      end
    endfunction

    function void check_beat(frame_beat_t got);
      frame_beat_t exp;
      if (expected_q.size() == 0) begin
        if (errors < MaxReports) begin
          $display("ERROR beat %0d: unexpected output data=%02h end=%b last=%b",
                   beats_seen, got.data, got.blk_end, got.last);
        end
        errors++;
      end else begin
        exp = expected_q.pop_front();
        if (got.data !== exp.data || got.blk_end !== exp.blk_end ||
            got.last !== exp.last) begin
          if (errors < MaxReports) begin
            $display("ERROR beat %0d: exp data=%02h end=%b last=%b, got data=%02h end=%b last=%b",
                     beats_seen, exp.data, exp.blk_end, exp.last,
                     got.data, got.blk_end, got.last);
          end
          errors++;
        end
      end
      beats_seen++;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  sfcp_snap_if  snap_if ();
  sfcp_frame_if frame_if ();

  frame_beat_checker frame_chk = new();

  rx_mode_e    rx_mode   = RX_ALWAYS;
  int unsigned hold_left = 0;
  int unsigned run_cycles;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  status_frame_crc_packer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .snap_i  (snap_if),
    .frame_o (frame_if)
  );

  task automatic drive_snap(input snap_t s, input logic v);
    snap_if.valid         <= v;
    snap_if.record_byte_0 <= s.rec[0];
    snap_if.record_byte_1 <= s.rec[1];
    snap_if.record_byte_2 <= s.rec[2];
    snap_if.record_byte_3 <= s.rec[3];
    snap_if.record_byte_4 <= s.rec[4];
    snap_if.serial_byte_0 <= s.ser[0];
    snap_if.serial_byte_1 <= s.ser[1];
    snap_if.serial_byte_2 <= s.ser[2];
    snap_if.charge_level  <= s.charge;
    snap_if.health_level  <= s.health;
    snap_if.cycle_count   <= s.cycles;
    snap_if.device_state  <= s.state;
  endtask

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_snap(input snap_t s);
    drive_snap(s, 1'b1);
    do begin
      @(posedge clk_i);
    end while (!snap_if.ready);
    frame_chk.note_snapshot(s);
  endtask

  task automatic idle_cycles(input int unsigned n);
    if (n > 0) begin
      snap_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (frame_chk.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic snap_t fill_snap(byte_t v, logic [15:0] c);
    snap_t s;
    s.rec    = {5{v}};
    s.ser    = {3{v}};
    s.charge = v;
    s.health = v;
    s.cycles = c;
    s.state  = v;
    return s;
  endfunction

  // extremes show up often, the rest is uniform
  function automatic byte_t pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return byte_t'($urandom);
    endcase
  endfunction

  function automatic snap_t random_snap();
    snap_t s;
    for (int k = 0; k < 5; k++) begin
      s.rec[k] = pick_byte();
    end
    for (int k = 0; k < 3; k++) begin
      s.ser[k] = pick_byte();
    end
    s.charge = pick_byte();
    s.health = pick_byte();
    s.cycles = {pick_byte(), pick_byte()};
    s.state  = pick_byte();
    return s;
  endfunction

  task automatic run_phase(input int unsigned n, input int unsigned max_burst,
                           input int unsigned max_gap, input rx_mode_e mode);
    int unsigned left;
    int unsigned burst;
    left    = n;
    rx_mode = mode;
    while (left > 0) begin
      burst = $urandom_range(1, max_burst);
      while (burst > 0 && left > 0) begin
        send_snap(random_snap());
        burst--;
        left--;
      end
      if (max_gap > 0) begin
        idle_cycles($urandom_range(0, max_gap));
      end
    end
  endtask

  // output side: check accepted bytes, then choose next ready
  initial begin
    frame_beat_t rx_beat;
    logic [7:0]  stall_pattern;
    stall_pattern  = 8'b1101_1001;
    frame_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (frame_if.valid && frame_if.ready) begin
        rx_beat.data    = frame_if.frame_byte;
        rx_beat.blk_end = frame_if.block_end;
        rx_beat.last    = frame_if.frame_last;
        frame_chk.check_beat(rx_beat);
      end
      stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      if (!rst_ni) begin
        frame_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        frame_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_COIN:    frame_if.ready <= 1'($urandom_range(0, 1));
          RX_PATTERN: frame_if.ready <= stall_pattern[0];
          RX_MOSTLY:  frame_if.ready <= ($urandom_range(0, 7) != 0);
          default:    frame_if.ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    run_cycles = 0;
    while (run_cycles < CycleLimit) begin
      @(posedge clk_i);
      run_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    snap_t s;
    rst_ni <= 1'b0;
    drive_snap(fill_snap(8'h00, 16'h0000), 1'b0);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner values, sent back to back
    rx_mode = RX_ALWAYS;
    send_snap(fill_snap(8'h00, 16'h0000));
    send_snap(fill_snap(8'hFF, 16'hFFFF));
    send_snap(fill_snap(8'h00, 16'hFFFF));
    send_snap(fill_snap(8'hFF, 16'h0000));
    send_snap(fill_snap(8'h55, 16'h00FF));
    send_snap(fill_snap(8'hAA, 16'hFF00));
    s.rec    = {8'h10, 8'h08, 8'h04, 8'h02, 8'h01};
    s.ser    = {8'h80, 8'h40, 8'h20};
    s.charge = 8'h80;
    s.health = 8'h01;
    s.cycles = 16'h8001;
    s.state  = 8'h7F;
    send_snap(s);
    for (int i = 0; i < 8; i++) begin
      send_snap(fill_snap(8'h01 << i, 16'h0101 << i));
    end

    // long output stall while input keeps coming, then drain fully
    hold_left = 300;
    for (int i = 0; i < 6; i++) begin
      send_snap(random_snap());
    end
    idle_cycles(1);
    wait_drained();

    run_phase(78, 1, 40, RX_ALWAYS);
    run_phase(78, 8, 6, RX_COIN);
    run_phase(78, 20, 0, RX_MOSTLY);
    run_phase(78, 4, 30, RX_PATTERN);
    run_phase(78, 6, 12, RX_COIN);

    idle_cycles(1);
    rx_mode = RX_ALWAYS;
    wait_drained();
    repeat (40) @(posedge clk_i);

    if (frame_chk.errors == 0 && frame_chk.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
